// ===== sv/slcan_pkg.sv =====
// Shared types, constants and helpers for the SLCAN line encoder.
package slcan_pkg;

	localparam int unsigned FIFO_DEPTH_DEF = 2;

	localparam logic [7:0] CH_DATA   = 8'h74; // 't'
	localparam logic [7:0] CH_REMOTE = 8'h72; // 'r'
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CASE_OFS  = 8'd32;
	localparam logic [7:0] HEX_NUM   = 8'h30;
	localparam logic [7:0] HEX_ALPHA = 8'h37;
	localparam logic [3:0] HEX_TEN   = 4'hA;
	localparam logic [3:0] MAX_BYTES = 4'd8;

	localparam logic [2:0] STD_DIG_LAST = 3'd2;
	localparam logic [2:0] EXT_DIG_LAST = 3'd7;
	localparam logic [4:0] TS_DIG_LAST  = 5'd3;

	// one classified frame, ready for the serialiser
	typedef struct packed {
		logic [7:0]  type_char;
		logic [31:0] id_digits;   // left aligned: next digit in the top nibble
		logic [2:0]  id_last;     // identifier digits minus one
		logic [3:0]  dlc;
		logic [3:0]  nbytes;
		logic [63:0] payload;
		logic [15:0] timestamp;
		logic        ts_en;
	} desc_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TYPE,
		ST_ID,
		ST_DLC,
		ST_DATA,
		ST_TS,
		ST_CR
	} state_t;

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		hex_char = (n < HEX_TEN) ? (HEX_NUM + {4'd0, n}) : (HEX_ALPHA + {4'd0, n});
	endfunction

endpackage

// ===== sv/slcan_fifo.sv =====
// Small register queue between the frame classifier and the serialiser.
module slcan_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] rdata
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [AW-1:0]    wptr_q;
	logic [AW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CNT_FULL);
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign rdata     = entry_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PTR_LAST) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wptr_q] <= wdata;
		end
	end

endmodule

// ===== sv/slcan_front.sv =====
// Input side: takes frames, holds the timestamp switch and classifies each frame.
module slcan_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic               cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [28:0]        frame_id,
	input  logic               extended,
	input  logic               remote,
	input  logic [3:0]         dlc,
	input  logic [63:0]        payload,
	input  logic [15:0]        timestamp,
	input  logic               q_full,
	output logic               q_push,
	output slcan_pkg::desc_t   q_desc
);
	import slcan_pkg::*;

	logic       ts_en_q;
	logic [7:0] base_char;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_en_q <= 1'b0;
		end else if (cfg_write) begin
			ts_en_q <= cfg_data;
		end
	end

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	assign base_char = remote ? CH_REMOTE : CH_DATA;

	always_comb begin
		q_desc.type_char = extended ? (base_char - CASE_OFS) : base_char;
		// standard frames show only the low 12 bits
		q_desc.id_digits = extended ? {3'd0, frame_id} : {frame_id[11:0], 20'd0};
		q_desc.id_last   = extended ? EXT_DIG_LAST : STD_DIG_LAST;
		q_desc.dlc       = dlc;
		q_desc.nbytes    = (dlc > MAX_BYTES) ? MAX_BYTES : dlc;
		q_desc.payload   = payload;
		q_desc.timestamp = timestamp;
		q_desc.ts_en     = ts_en_q;
	end

endmodule

// ===== sv/slcan_back.sv =====
// Output side: walks one classified frame and sends its line a character a beat.
module slcan_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_not_empty,
	input  slcan_pkg::desc_t   q_desc,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         character,
	output logic               last_char
);
	import slcan_pkg::*;

	state_t      state_q;
	state_t      state_d;
	logic [4:0]  cnt_q;
	logic [7:0]  type_q;
	logic [31:0] id_sh_q;
	logic [2:0]  id_last_q;
	logic [3:0]  dlc_q;
	logic [3:0]  nbytes_q;
	logic [63:0] data_sh_q;
	logic [15:0] ts_sh_q;
	logic        ts_en_q;

	logic        out_valid_q;
	logic [7:0]  char_q;
	logic        last_q;

	logic        adv;
	logic        emit;
	logic [7:0]  char_d;
	logic        last_d;
	logic        cnt_zero;
	logic [4:0]  data_last;

	assign adv       = !out_valid_q || !out_stall;
	assign cnt_zero  = (cnt_q == '0);
	assign data_last = {nbytes_q, 1'b0} - 5'd1;
	assign q_pop     = (state_q == ST_IDLE) && adv && q_not_empty;

	// next state
	always_comb begin
		state_d = state_q;
		if (adv) begin
			case (state_q)
				ST_IDLE: if (q_not_empty) state_d = ST_TYPE;
				ST_TYPE: state_d = ST_ID;
				ST_ID:   if (cnt_zero) state_d = ST_DLC;
				ST_DLC: begin
					if (nbytes_q != '0) state_d = ST_DATA;
					else if (ts_en_q)   state_d = ST_TS;
					else                state_d = ST_CR;
				end
				ST_DATA: if (cnt_zero) state_d = ts_en_q ? ST_TS : ST_CR;
				ST_TS:   if (cnt_zero) state_d = ST_CR;
				ST_CR:   state_d = ST_IDLE;
				default: state_d = ST_IDLE;
			endcase
		end
	end

	// character for the current state
	always_comb begin
		emit   = 1'b1;
		last_d = 1'b0;
		char_d = CH_CR;
		case (state_q)
			ST_IDLE: emit = 1'b0;
			ST_TYPE: char_d = type_q;
			ST_ID:   char_d = hex_char(id_sh_q[31:28]);
			ST_DLC:  char_d = hex_char(dlc_q);
			ST_DATA: char_d = hex_char(data_sh_q[63:60]);
			ST_TS:   char_d = hex_char(ts_sh_q[15:12]);
			ST_CR:   last_d = 1'b1;
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			state_q     <= state_d;
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			char_q <= char_d;
			last_q <= last_d;
			case (state_q)
				ST_IDLE: begin
					type_q    <= q_desc.type_char;
					id_sh_q   <= q_desc.id_digits;
					id_last_q <= q_desc.id_last;
					dlc_q     <= q_desc.dlc;
					nbytes_q  <= q_desc.nbytes;
					data_sh_q <= q_desc.payload;
					ts_sh_q   <= q_desc.timestamp;
					ts_en_q   <= q_desc.ts_en;
				end
				ST_TYPE: cnt_q <= {2'd0, id_last_q};
				ST_ID: begin
					id_sh_q <= {id_sh_q[27:0], 4'd0};
					cnt_q   <= cnt_q - 5'd1;
				end
				ST_DLC:  cnt_q <= (nbytes_q != '0) ? data_last : TS_DIG_LAST;
				ST_DATA: begin
					data_sh_q <= {data_sh_q[59:0], 4'd0};
					cnt_q     <= cnt_zero ? TS_DIG_LAST : cnt_q - 5'd1;
				end
				ST_TS: begin
					ts_sh_q <= {ts_sh_q[11:0], 4'd0};
					cnt_q   <= cnt_q - 5'd1;
				end
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last_char = last_q;

endmodule

// ===== sv/can_frame_to_slcan_ascii.sv =====
// Top level of the CAN frame to SLCAN ASCII line encoder.
//
//  channel | direction | handshake          | beat
//  --------+-----------+--------------------+---------------------------------------------
//  cfg     | in        | cfg_write          | cfg_data -> timestamp switch
//  in      | in        | in_valid/in_stall  | frame_id, extended, remote, dlc, payload, ts
//  out     | out       | out_valid/out_stall| character, last_char
//
// The serialiser picks each frame up from the queue in its idle state before
// the line, which holds 6 to 31 characters.
// The queue holds FIFO_DEPTH frames, so input is taken while a line is sent until the queue is full.
// Reset clears the queue, the serialiser state and the timestamp switch.
// A stalled output beat holds; the serialiser waits on it.
module can_frame_to_slcan_ascii #(
	parameter int unsigned FIFO_DEPTH = slcan_pkg::FIFO_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [28:0] frame_id,
	input  logic        extended,
	input  logic        remote,
	input  logic [3:0]  dlc,
	input  logic [63:0] payload,
	input  logic [15:0] timestamp,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  character,
	output logic        last_char
);
	import slcan_pkg::*;

	localparam int unsigned DESC_W = $bits(desc_t);

	desc_t             push_desc;
	desc_t             pop_desc;
	logic [DESC_W-1:0] pop_bits;
	logic              q_push;
	logic              q_full;
	logic              q_pop;
	logic              q_not_empty;

	slcan_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.frame_id  (frame_id),
		.extended  (extended),
		.remote    (remote),
		.dlc       (dlc),
		.payload   (payload),
		.timestamp (timestamp),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_desc    (push_desc)
	);

	slcan_fifo #(
		.WIDTH (DESC_W),
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wdata     (push_desc),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.rdata     (pop_bits)
	);

	assign pop_desc = desc_t'(pop_bits);

	slcan_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_desc      (pop_desc),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.character   (character),
		.last_char   (last_char)
	);

endmodule

// ===== sv/slcan_checker.sv =====
// Port-level checks on the SLCAN encoder output, bound to the top level.
module slcan_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] character,
	input logic       last_char
);
	import slcan_pkg::*;

	// a stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(character) && $stable(last_char))
		else $error("stalled output beat changed");

	a_last_is_cr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_char |-> character == CH_CR)
		else $error("last beat is not a carriage return");

	a_cr_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && character == CH_CR |-> last_char)
		else $error("carriage return not marked last");

	// the serialiser goes idle to fetch the next frame after a line ends
	a_gap_after_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_char |=> !out_valid)
		else $error("beat directly after end of line");

endmodule

bind can_frame_to_slcan_ascii slcan_checker u_slcan_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.character (character),
	.last_char (last_char)
);

// ===== sim/tb.sv =====
// Self-checking testbench for the CAN frame to SLCAN ASCII line encoder.
`timescale 1ns / 100ps

module tb;

	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_CYCLES = 40;

	localparam logic [7:0] ASC_DIGIT  = 8'h30;  // '0'
	localparam logic [7:0] ASC_LETTER = 8'h37;  // 'A' minus ten
	localparam logic [3:0] NIB_TEN    = 4'hA;
	localparam logic [7:0] ASC_DATA   = 8'h74;  // 't'
	localparam logic [7:0] ASC_REMOTE = 8'h72;  // 'r'
	localparam logic [7:0] ASC_CR     = 8'h0D;
	localparam logic [7:0] UPPER_OFS  = 8'd32;
	localparam int STD_DIGITS = 3;
	localparam int EXT_DIGITS = 8;
	localparam int TS_DIGITS  = 4;
	localparam int MAX_BYTES  = 8;

	typedef struct {
		logic [28:0] id;
		logic        ext;
		logic        rtr;
		logic [3:0]  len;
		logic [63:0] data;
		logic [15:0] stamp;
	} can_frame_t;

	typedef struct {
		logic [7:0] ch;
		logic       last;
	} slcan_char_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_write;
	logic        cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [28:0] frame_id;
	logic        extended;
	logic        remote;
	logic [3:0]  dlc;
	logic [63:0] payload;
	logic [15:0] timestamp;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  character;
	logic        last_char;

	slcan_char_t line_chars[$];
	slcan_char_t want;
	logic        ts_enabled;
	bit          bursty;
	int          burst_left;
	int          mismatches;
	int          frames_sent;
	int          chars_checked;
	int          cycle_count;
	int          stall_left;
	int          stall_phase;
	int          stall_mode;

	can_frame_to_slcan_ascii DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.frame_id  (frame_id),
		.extended  (extended),
		.remote    (remote),
		.dlc       (dlc),
		.payload   (payload),
		.timestamp (timestamp),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.character (character),
		.last_char (last_char)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d characters still awaited", $time, line_chars.size());
			$display("FAIL can_frame_to_slcan_ascii");
			$finish;
		end
	end

	// receiver: switches between no stalls, random stalls and long holds
	always @(negedge clk) begin
		stall_phase++;
		if (stall_phase % 200 == 0)
			stall_mode = $urandom_range(0, 3);
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 2) == 0);
				2: begin
					if ($urandom_range(0, 15) == 0)
						stall_left = $urandom_range(4, 20);
					out_stall <= (stall_left != 0);
				end
				default: out_stall <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			chars_checked++;
			if (line_chars.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected beat, expected none, got char %h last %b",
					$time, character, last_char);
			end else begin
				want = line_chars.pop_front();
				if (character !== want.ch) begin
					mismatches++;
					$display("%0t: character expected %h, got %h", $time, want.ch, character);
				end
				if (last_char !== want.last) begin
					mismatches++;
					$display("%0t: last_char expected %b, got %b", $time, want.last, last_char);
				end
			end
		end
	end

	function automatic logic [7:0] ascii_hex(input logic [3:0] n);
		return (n < NIB_TEN) ? ASC_DIGIT + {4'd0, n} : ASC_LETTER + {4'd0, n};
	endfunction

	function automatic void push_char(input logic [7:0] c, input logic last);
		slcan_char_t e;
		e.ch = c;
		e.last = last;
		line_chars.push_back(e);
	endfunction

	// expected SLCAN text for one accepted frame
	function automatic void predict_line(input can_frame_t f);
		logic [31:0] id32;
		logic [7:0]  type_ch;
		logic [7:0]  b;
		int          digits;
		int          nbytes;
		int          i;
		id32 = {3'd0, f.id};
		type_ch = f.rtr ? ASC_REMOTE : ASC_DATA;
		if (f.ext)
			type_ch = type_ch - UPPER_OFS;
		push_char(type_ch, 1'b0);
		digits = f.ext ? EXT_DIGITS : STD_DIGITS;
		for (i = digits - 1; i >= 0; i--)
			push_char(ascii_hex(id32[4*i +: 4]), 1'b0);
		push_char(ascii_hex(f.len), 1'b0);
		nbytes = (f.len > MAX_BYTES) ? MAX_BYTES : f.len;
		for (i = 0; i < nbytes; i++) begin
			b = f.data[63 - 8*i -: 8];
			push_char(ascii_hex(b[7:4]), 1'b0);
			push_char(ascii_hex(b[3:0]), 1'b0);
		end
		if (ts_enabled)
			for (i = TS_DIGITS - 1; i >= 0; i--)
				push_char(ascii_hex(f.stamp[4*i +: 4]), 1'b0);
		push_char(ASC_CR, 1'b1);
	endfunction

	function automatic can_frame_t mk_frame(input logic [28:0] id, input logic ext,
			input logic rtr, input logic [3:0] len, input logic [63:0] data,
			input logic [15:0] stamp);
		can_frame_t f;
		f.id = id;
		f.ext = ext;
		f.rtr = rtr;
		f.len = len;
		f.data = data;
		f.stamp = stamp;
		return f;
	endfunction

	function automatic can_frame_t random_frame();
		can_frame_t f;
		f.id = 29'($urandom);
		case ($urandom_range(0, 7))
			0: f.id = '0;
			1: f.id = '1;
			default: ;
		endcase
		f.ext = 1'($urandom_range(0, 1));
		f.rtr = ($urandom_range(0, 3) == 0);
		f.len = 4'(($urandom_range(0, 4) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8));
		f.data = {$urandom, $urandom};
		f.stamp = 16'($urandom);
		return f;
	endfunction

	task automatic send_frame(input can_frame_t f);
		int gap;
		@(negedge clk);
		if (bursty && burst_left == 0) begin
			burst_left = $urandom_range(1, 10);
			gap = $urandom_range(1, 7);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		if (burst_left > 0)
			burst_left--;
		frame_id  <= f.id;
		extended  <= f.ext;
		remote    <= f.rtr;
		dlc       <= f.len;
		payload   <= f.data;
		timestamp <= f.stamp;
		in_valid  <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		predict_line(f);
		frames_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (line_chars.size() != 0)
			@(posedge clk);
	endtask

	// only written with the encoder idle
	task automatic set_timestamp(input logic en);
		drain();
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_data  <= en;
		@(negedge clk);
		cfg_write <= 1'b0;
		ts_enabled = en;
	endtask

	task automatic test_identifiers_and_dlc();
		int n;
		bursty = 0;
		set_timestamp(1'b0);
		send_frame(mk_frame(29'h0, 1'b0, 1'b0, 4'd0, 64'h0, 16'h0));
		send_frame(mk_frame(29'hFFF, 1'b0, 1'b0, 4'd8, '1, 16'hFFFF));
		// upper identifier bits hidden on a standard frame
		send_frame(mk_frame(29'h1FFFFFFF, 1'b0, 1'b0, 4'd1, 64'hA5A5_A5A5_A5A5_A5A5, 16'h0));
		send_frame(mk_frame(29'h0, 1'b1, 1'b0, 4'd8, 64'h0123_4567_89AB_CDEF, 16'h0));
		send_frame(mk_frame(29'h1FFFFFFF, 1'b1, 1'b0, 4'd8, 64'hFEDC_BA98_7654_3210, 16'h0));
		send_frame(mk_frame(29'h123, 1'b0, 1'b1, 4'd0, '1, 16'h0));
		// remote frames still carry data digits
		send_frame(mk_frame(29'h0ABCDEF0, 1'b1, 1'b1, 4'd2, 64'h5A3C_0000_0000_0000, 16'h0));
		for (n = 9; n <= 15; n++)
			send_frame(mk_frame(29'(29'h0F0F0F0F ^ n), n[0], n[1], n[3:0],
				64'h8040_2010_0804_0201 << n, 16'h0));
	endtask

	task automatic test_timestamp_digits();
		bursty = 1;
		set_timestamp(1'b1);
		send_frame(mk_frame(29'h7FF, 1'b0, 1'b0, 4'd0, 64'h0, 16'h0000));
		// longest line: extended, capped data, timestamp
		send_frame(mk_frame(29'h1FFFFFFF, 1'b1, 1'b0, 4'd15, '1, 16'hFFFF));
		send_frame(mk_frame(29'h456, 1'b0, 1'b1, 4'd8, 64'h1122_3344_5566_7788, 16'h1234));
		send_frame(mk_frame(29'h10000001, 1'b1, 1'b0, 4'd4, 64'hDEAD_BEEF_0000_0000, 16'hABCD));
		send_frame(mk_frame(29'h89A, 1'b0, 1'b0, 4'd8, 64'h00FF_00FF_00FF_00FF, 16'h0F0F));
	endtask

	task automatic test_random_frames(input int count, input logic ts_on, input bit gaps);
		int n;
		set_timestamp(ts_on);
		bursty = gaps;
		for (n = 0; n < count; n++)
			send_frame(random_frame());
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_data = 1'b0;
		in_valid = 1'b0;
		frame_id = '0;
		extended = 1'b0;
		remote = 1'b0;
		dlc = '0;
		payload = '0;
		timestamp = '0;
		out_stall = 1'b0;
		ts_enabled = 1'b0;
		stall_mode = 1;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_identifiers_and_dlc();
		test_timestamp_digits();
		test_random_frames(35, 1'b1, 1);
		test_random_frames(35, 1'b0, 1);
		test_random_frames(35, 1'b1, 0);
		test_random_frames(35, 1'b0, 0);

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d frames encoded, %0d characters checked", frames_sent, chars_checked);
		$display("timestamp digits on and off, standard/extended, remote, dlc 0 to 15");
		if (mismatches == 0 && line_chars.size() == 0)
			$display("PASS can_frame_to_slcan_ascii");
		else
			$display("FAIL can_frame_to_slcan_ascii");
		$finish;
	end

endmodule
